@@ rtl/core/frasm_pkg.sv @@
// ----------------------------------------------------------------------------
// frasm_pkg
// Shared types and codes for the fragment reassembler: command and result
// transfers, action and status codes, header check results.
// ----------------------------------------------------------------------------
package frasm_pkg;

	// action codes
	localparam logic [1:0] ACT_DATA  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// result status codes
	localparam logic [1:0] ST_INCOMPLETE = 2'd0;
	localparam logic [1:0] ST_COMPLETE   = 2'd1;
	localparam logic [1:0] ST_ERROR      = 2'd2;
	localparam logic [1:0] ST_READ       = 2'd3;

	// one command transfer
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] frag_idx;
		logic [15:0] frag_cnt;
		logic [31:0] msg_total;
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        last_of_fragment;
		logic [8:0]  read_offset;
	} frasm_in_t;

	// one result transfer
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_byte;
		logic [9:0] slot_length;
		logic       slot_received;
		logic [6:0] received_count;
	} frasm_out_t;

	// header check outcome for the first item of a fragment
	typedef struct packed {
		logic bad;
		logic start_entry;
	} frasm_hdr_t;

endpackage

@@ rtl/core/frasm_hdr_check.sv @@
// ----------------------------------------------------------------------------
// frasm_hdr_check
// Checks a fragment header against the caps and against the started entry,
// and tells whether this header opens a new entry.
// ----------------------------------------------------------------------------
module frasm_hdr_check #(
	parameter int MAX_FRAGMENTS = 64,
	parameter int MAX_MESSAGE_BYTES = 32768,
	localparam int FCNT_W = $clog2(MAX_FRAGMENTS + 1),
	localparam int ELEN_W = $clog2(MAX_MESSAGE_BYTES + 1)
) (
	input  frasm_pkg::frasm_in_t  cmd,
	input  logic                  entry_started,
	input  logic [FCNT_W-1:0]     exp_frags,
	input  logic [ELEN_W-1:0]     exp_len,
	output frasm_pkg::frasm_hdr_t hdr
);
	import frasm_pkg::*;

	logic cap_bad;
	logic mismatch;

	// caps on count, total and index
	assign cap_bad = (cmd.frag_cnt == 16'd0)
		|| (cmd.frag_cnt > 16'(MAX_FRAGMENTS))
		|| (cmd.msg_total > 32'(MAX_MESSAGE_BYTES))
		|| (cmd.frag_idx >= cmd.frag_cnt);

	// agreement with an entry already under way
	assign mismatch = entry_started
		&& ((cmd.frag_cnt != 16'(exp_frags)) || (cmd.msg_total != 32'(exp_len)));

	assign hdr.bad         = cap_bad || mismatch;
	assign hdr.start_entry = !cap_bad && !entry_started;

endmodule

@@ rtl/core/fragment_reassembler.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembler
// Rebuilds one message from indexed fragments received a byte per transfer,
// with read-back of stored slot bytes and an entry clear.
// ----------------------------------------------------------------------------
// Fragment data items and clears are taken one per cycle with busy low; the
// result of a fragment's last item shows on result with done high in the
// cycle after its transfer. On a read, the slot length memory and the byte
// store are read into the read stage registers, then the offset is checked
// against the stored length, so busy is high while the read stage holds the
// read, and the read result follows in the next cycle. Each result is
// shown for exactly one cycle and must be captured then; there is no
// backpressure. Slot bytes and slot lengths live in synchronous memories
// that are not cleared by reset; only received slots are ever read back.
// ----------------------------------------------------------------------------
module fragment_reassembler #(
	parameter int MAX_FRAGMENTS = 64,
	parameter int MAX_MESSAGE_BYTES = 32768,
	parameter int SLOT_BYTES = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  frasm_pkg::frasm_in_t  cmd,
	output logic                  done,
	output frasm_pkg::frasm_out_t result
);
	import frasm_pkg::*;

	localparam int SLOT_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int FCNT_W = $clog2(MAX_FRAGMENTS + 1);
	localparam int BCNT_W = $clog2(SLOT_BYTES + 1);
	localparam int DEPTH  = MAX_FRAGMENTS * SLOT_BYTES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ELEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int SUM_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (ELEN_W > SUM_W) ? ELEN_W : SUM_W;

	// entry state
	logic                     started_q;
	logic [FCNT_W-1:0]        exp_frags_q;
	logic [ELEN_W-1:0]        exp_len_q;
	logic [FCNT_W-1:0]        rcv_q;
	logic [SUM_W-1:0]         sum_q;
	logic [MAX_FRAGMENTS-1:0] map_q;

	// fragment in progress
	logic              in_frag_q;
	logic              err_q;
	logic              store_q;
	logic              ovf_q;
	logic [BCNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] slot_q;

	// memories
	logic [7:0]        store_mem [DEPTH];
	logic [BCNT_W-1:0] len_mem [MAX_FRAGMENTS];

	// read stage
	logic              rd_s1;
	logic              rcvd_s1;
	logic              off_ok_s1;
	logic [8:0]        off_s1;
	logic [7:0]        byte_rd_s1;
	logic [BCNT_W-1:0] len_rd_s1;

	// result register
	logic       done_q;
	frasm_out_t result_q;

	// transfer decode
	logic accept, data_acc, read_acc, clear_acc;
	assign accept    = start && !busy;
	assign data_acc  = accept && (cmd.action == ACT_DATA);
	assign read_acc  = accept && (cmd.action == ACT_READ);
	assign clear_acc = accept && (cmd.action == ACT_CLEAR);
	assign busy      = rd_s1;

	// header check
	frasm_hdr_t hdr;
	frasm_hdr_check #(
		.MAX_FRAGMENTS    (MAX_FRAGMENTS),
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_hdr (
		.cmd          (cmd),
		.entry_started(started_q),
		.exp_frags    (exp_frags_q),
		.exp_len      (exp_len_q),
		.hdr          (hdr)
	);

	// effective state for this data item
	logic                     first, start_now;
	logic [SLOT_W-1:0]        idx_slot;
	logic [FCNT_W-1:0]        exp_frags_e, rcv_base, rcv_n;
	logic [ELEN_W-1:0]        exp_len_e;
	logic [SUM_W-1:0]         sum_base, sum_n;
	logic [MAX_FRAGMENTS-1:0] map_base, map_n;
	logic                     err_e, store_e, ovf_e, ovf_n, over, ok, commit;
	logic [BCNT_W-1:0]        cnt_e, cnt_n;
	logic [SLOT_W-1:0]        slot_e;
	logic                     store_we;
	logic [ADDR_W-1:0]        wr_addr;
	logic [1:0]               frag_status;

	always_comb begin
		first     = !in_frag_q;
		start_now = first && hdr.start_entry;
		idx_slot  = cmd.frag_idx[SLOT_W-1:0];

		exp_frags_e = start_now ? FCNT_W'(cmd.frag_cnt) : exp_frags_q;
		exp_len_e   = start_now ? ELEN_W'(cmd.msg_total) : exp_len_q;
		rcv_base    = start_now ? '0 : rcv_q;
		sum_base    = start_now ? '0 : sum_q;
		map_base    = start_now ? '0 : map_q;

		err_e   = first ? hdr.bad : err_q;
		store_e = first ? (!hdr.bad && !map_base[idx_slot]) : store_q;
		ovf_e   = first ? 1'b0 : ovf_q;
		cnt_e   = first ? '0 : cnt_q;
		slot_e  = first ? (hdr.bad ? '0 : idx_slot) : slot_q;

		// byte step: bytes past the slot size set overflow
		over     = cnt_e >= BCNT_W'(SLOT_BYTES);
		ovf_n    = ovf_e || (cmd.has_byte && over);
		cnt_n    = cnt_e + BCNT_W'(cmd.has_byte && !over);
		store_we = data_acc && cmd.has_byte && !over && store_e;
		wr_addr  = ADDR_W'(ADDR_W'(slot_e) * ADDR_W'(SLOT_BYTES)) + ADDR_W'(cnt_e);

		// end of fragment bookkeeping
		ok     = !err_e && !ovf_n;
		commit = ok && store_e && cmd.last_of_fragment;
		rcv_n  = rcv_base + FCNT_W'(commit);
		sum_n  = sum_base + (commit ? SUM_W'(cnt_n) : '0);
		map_n  = map_base | (commit ? (MAX_FRAGMENTS'(1) << slot_e) : '0);

		if (!ok) begin
			frag_status = ST_ERROR;
		end else if (rcv_n < exp_frags_e) begin
			frag_status = ST_INCOMPLETE;
		end else if (CMP_W'(sum_n) == CMP_W'(exp_len_e)) begin
			frag_status = ST_COMPLETE;
		end else begin
			frag_status = ST_ERROR;
		end
	end

	// entry and fragment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			exp_frags_q <= '0;
			exp_len_q   <= '0;
			rcv_q       <= '0;
			sum_q       <= '0;
			map_q       <= '0;
			in_frag_q   <= 1'b0;
			err_q       <= 1'b0;
			store_q     <= 1'b0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			slot_q      <= '0;
		end else if (clear_acc) begin
			started_q   <= 1'b0;
			exp_frags_q <= '0;
			exp_len_q   <= '0;
			rcv_q       <= '0;
			sum_q       <= '0;
			map_q       <= '0;
			in_frag_q   <= 1'b0;
			err_q       <= 1'b0;
			store_q     <= 1'b0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			slot_q      <= '0;
		end else if (data_acc) begin
			started_q   <= started_q || start_now;
			exp_frags_q <= exp_frags_e;
			exp_len_q   <= exp_len_e;
			rcv_q       <= rcv_n;
			sum_q       <= sum_n;
			map_q       <= map_n;
			in_frag_q   <= !cmd.last_of_fragment;
			if (cmd.last_of_fragment) begin
				err_q   <= 1'b0;
				store_q <= 1'b0;
				ovf_q   <= 1'b0;
				cnt_q   <= '0;
				slot_q  <= '0;
			end else begin
				err_q   <= err_e;
				store_q <= store_e;
				ovf_q   <= ovf_n;
				cnt_q   <= cnt_n;
				slot_q  <= slot_e;
			end
		end
	end

	// read address decode
	logic              rd_idx_ok, rd_rcvd, rd_off_ok;
	logic [SLOT_W-1:0] rd_slot;
	logic [ADDR_W-1:0] rd_addr;
	assign rd_idx_ok = cmd.frag_idx < 16'(MAX_FRAGMENTS);
	assign rd_slot   = cmd.frag_idx[SLOT_W-1:0];
	assign rd_rcvd   = rd_idx_ok && map_q[rd_slot];
	assign rd_off_ok = 32'(cmd.read_offset) < 32'(SLOT_BYTES);
	assign rd_addr   = ADDR_W'(ADDR_W'(rd_slot) * ADDR_W'(SLOT_BYTES))
		+ (rd_off_ok ? ADDR_W'(cmd.read_offset) : '0);

	// byte store and slot length memories
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[wr_addr] <= cmd.data_byte;
		end
		if (data_acc && commit) begin
			len_mem[slot_e] <= cnt_n;
		end
		if (read_acc) begin
			byte_rd_s1 <= store_mem[rd_addr];
			len_rd_s1  <= len_mem[rd_slot];
			rcvd_s1    <= rd_rcvd;
			off_ok_s1  <= rd_off_ok;
			off_s1     <= cmd.read_offset;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= read_acc;
		end
	end

	// read result: offset checked against the stored length
	logic [BCNT_W-1:0] rd_len;
	logic [7:0]        rd_byte;
	always_comb begin
		rd_len  = rcvd_s1 ? len_rd_s1 : '0;
		rd_byte = (rcvd_s1 && off_ok_s1 && (32'(off_s1) < 32'(rd_len))) ? byte_rd_s1 : 8'd0;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rd_s1 || (data_acc && cmd.last_of_fragment);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			result_q.status         <= ST_READ;
			result_q.read_byte      <= rd_byte;
			result_q.slot_length    <= 10'(rd_len);
			result_q.slot_received  <= rcvd_s1;
			result_q.received_count <= 7'(rcv_q);
		end else if (data_acc && cmd.last_of_fragment) begin
			result_q.status         <= frag_status;
			result_q.read_byte      <= 8'd0;
			result_q.slot_length    <= 10'd0;
			result_q.slot_received  <= 1'b0;
			result_q.received_count <= 7'(rcv_n);
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	// the read stage blocks transfers, so no fragment result can land in it
	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe during read stage");

	// the read stage is followed by the read result
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && (result.status == ST_READ)))
		else $error("read result missing after read stage");

	// distinct slots never exceed the declared count
	a_rcv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_q <= exp_frags_q)
		else $error("received fragments exceed declared count");

	// an idle entry holds no received slots
	a_idle_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!started_q |-> ((rcv_q == '0) && (map_q == '0) && (sum_q == '0)))
		else $error("entry state left over without a started entry");

	// received count tracks the slot map
	a_map_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(map_q)) == 32'(rcv_q))
		else $error("slot map and received count disagree");
`endif

endmodule
